/* rtl/clb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clb_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMD_W = 3;
    localparam int BYTE_W = 8;

    // read reduction: groups of GRP cells are OR-ed, then the group results are OR-ed together
    localparam int GRP = 8;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    localparam logic [CMD_W-1:0] CMD_FWD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BACK = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START = 3'd2;
    localparam logic [CMD_W-1:0] CMD_END = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ = 3'd6;

    typedef struct packed {
        logic               ins;
        logic               del;
        logic [CNT_W-1:0]   cursor;
        logic [BYTE_W-1:0]  ch;
        logic [IDX_W-1:0]   rd_idx;
    } clb_ctrl_t;

endpackage

`default_nettype wire

/* rtl/clb_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module clb_cell
    import clb_pkg::*;
(
    input  wire logic              clk,
    input  wire clb_ctrl_t         ctrl,
    input  wire logic [IDX_W-1:0]  my_index,
    input  wire logic [BYTE_W-1:0] left_byte,
    input  wire logic [BYTE_W-1:0] right_byte,
    output logic      [BYTE_W-1:0] data,
    output logic      [BYTE_W-1:0] sel_byte
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic [CNT_W-1:0]  pos;

    assign pos = CNT_W'(my_index);

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.ins)
        begin
            if (pos == ctrl.cursor)
                byte_next = ctrl.ch;
            else if (pos > ctrl.cursor)
                byte_next = left_byte;
        end
        else if (ctrl.del)
        begin
            // close the gap: everything from the cursor on takes its right neighbor
            if (pos >= ctrl.cursor)
                byte_next = right_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign data = byte_reg;
    assign sel_byte = (my_index == ctrl.rd_idx) ? byte_reg : '0;

endmodule

`default_nettype wire

/* rtl/clb_read_tree.sv */
`timescale 1ns / 1ps
`default_nettype none

module clb_read_tree
    import clb_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic [DEPTH-1:0][BYTE_W-1:0]  sel_bytes,
    output logic      [BYTE_W-1:0]             merged
);

    logic [NGRP-1:0][BYTE_W-1:0] part_reg;
    logic [NGRP-1:0][BYTE_W-1:0] part_next;

    always_comb
    begin
        part_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            for (int k = 0; k < GRP; k++)
            begin
                if (g * GRP + k < DEPTH)
                    part_next[g] = part_next[g] | sel_bytes[g * GRP + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
    end

    always_comb
    begin
        merged = '0;
        for (int g = 0; g < NGRP; g++)
            merged = merged | part_reg[g];
    end

endmodule

`default_nettype wire

/* rtl/cursor_line_edit_buffer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Line edit buffer built as a row of byte cells that shift together.
// Results pass through the s1 registers and then the output registers; done is
// registered from the s1 valid flag, alongside the result outputs.
// Throughput: one command per cycle; busy stays low and every command is taken.
// The read passes through a registered two-level OR tree alongside the s1 registers.
// Reset (rst_n low, asynchronous) clears cursor, length and the pipeline valid flags;
// byte contents and result data are left as they are. The receiver cannot stall results.

module cursor_line_edit_buffer
    import clb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [BYTE_W-1:0] char_in,
    input  wire logic [IDX_W-1:0]  read_index,
    output logic                   done,
    output logic      [CNT_W-1:0]  cursor_pos,
    output logic      [CNT_W-1:0]  fill_length,
    output logic      [BYTE_W-1:0] read_byte,
    output logic                   read_valid,
    output logic                   insert_dropped
);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic             accept;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rvalid_now, drop_now;
    clb_ctrl_t        ctrl;

    logic             s1_valid_reg;
    logic [CNT_W-1:0] s1_cursor_reg, s1_count_reg;
    logic             s1_rvalid_reg, s1_drop_reg;

    logic                         done_reg;
    logic [CNT_W-1:0]             cursor_out_reg, count_out_reg;
    logic [BYTE_W-1:0]            byte_out_reg;
    logic                         rvalid_out_reg, drop_out_reg;

    logic [DEPTH-1:0][BYTE_W-1:0] cell_data;
    logic [DEPTH-1:0][BYTE_W-1:0] sel_bytes;
    logic [BYTE_W-1:0]            merged;

    assign busy = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        cursor_next = cursor_reg;
        count_next = count_reg;
        rvalid_now = 1'b0;
        drop_now = 1'b0;
        ctrl.ins = 1'b0;
        ctrl.del = 1'b0;
        ctrl.cursor = cursor_reg;
        ctrl.ch = char_in;
        ctrl.rd_idx = read_index;
        if (accept)
        begin
            case (cmd)
                CMD_FWD:
                begin
                    if (cursor_reg < count_reg)
                        cursor_next = cursor_reg + 1'b1;
                end
                CMD_BACK:
                begin
                    if (cursor_reg != '0)
                        cursor_next = cursor_reg - 1'b1;
                end
                CMD_START:
                    cursor_next = '0;
                CMD_END:
                    cursor_next = count_reg;
                CMD_INSERT:
                begin
                    if (count_reg >= FULL)
                        drop_now = 1'b1;
                    else
                    begin
                        ctrl.ins = 1'b1;
                        count_next = count_reg + 1'b1;
                        cursor_next = cursor_reg + 1'b1;
                    end
                end
                CMD_DELETE:
                begin
                    if (cursor_reg < count_reg)
                    begin
                        ctrl.del = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_READ:
                    rvalid_now = CNT_W'(read_index) < count_reg;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            count_reg <= '0;
            s1_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            count_reg <= count_next;
            s1_valid_reg <= accept;
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cursor_reg <= cursor_next;
        s1_count_reg <= count_next;
        s1_rvalid_reg <= rvalid_now;
        s1_drop_reg <= drop_now;
        cursor_out_reg <= s1_cursor_reg;
        count_out_reg <= s1_count_reg;
        byte_out_reg <= s1_rvalid_reg ? merged : '0;
        rvalid_out_reg <= s1_rvalid_reg;
        drop_out_reg <= s1_drop_reg;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [BYTE_W-1:0] left_b, right_b;
        if (i == 0)
        begin : g_first
            assign left_b = char_in;
        end
        else
        begin : g_mid
            assign left_b = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_b = cell_data[i];
        end
        else
        begin : g_inner
            assign right_b = cell_data[i+1];
        end

        clb_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .my_index   (IDX_W'(i)),
            .left_byte  (left_b),
            .right_byte (right_b),
            .data       (cell_data[i]),
            .sel_byte   (sel_bytes[i])
        );
    end

    clb_read_tree u_tree (
        .clk       (clk),
        .sel_bytes (sel_bytes),
        .merged    (merged)
    );

    assign done = done_reg;
    assign cursor_pos = cursor_out_reg;
    assign fill_length = count_out_reg;
    assign read_byte = byte_out_reg;
    assign read_valid = rvalid_out_reg;
    assign insert_dropped = drop_out_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg <= count_reg) && (count_reg <= FULL))
        else $error("cursor or length out of range");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted command produced no result");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && insert_dropped) |-> (fill_length == FULL))
        else $error("insert dropped while buffer not full");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_valid) |-> (fill_length != '0) && !insert_dropped)
        else $error("read valid on empty buffer");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

import clb_pkg::*;

typedef struct packed {
    logic [CNT_W-1:0]  cursor;
    logic [CNT_W-1:0]  length;
    logic [BYTE_W-1:0] rbyte;
    logic              rvalid;
    logic              dropped;
} line_status_t;

// Shadow copy of the line buffer; each transfer pushes the status it must produce.
class line_shadow;
    logic [BYTE_W-1:0] line_bytes [DEPTH];
    int                held_len;
    int                cur;
    line_status_t      expected_status [$];
    int                errors;

    function new();
        held_len = 0;
        cur = 0;
        errors = 0;
    endfunction

    function int pending();
        return expected_status.size();
    endfunction

    function void note_command(logic [CMD_W-1:0] op, logic [BYTE_W-1:0] ch,
                               logic [IDX_W-1:0] ix);
        line_status_t st;
        st = '0;
        case (op)
            CMD_FWD: if (cur < held_len) cur++;
            CMD_BACK: if (cur > 0) cur--;
            CMD_START: cur = 0;
            CMD_END: cur = held_len;
            CMD_INSERT:
            begin
                if (held_len >= DEPTH) begin
                    st.dropped = 1'b1;
                end else begin
                    for (int i = held_len; i > cur; i--)
                        line_bytes[i] = line_bytes[i-1];
                    line_bytes[cur] = ch;
                    held_len++;
                    cur++;
                end
            end
            CMD_DELETE:
            begin
                if (cur < held_len) begin
                    for (int i = cur + 1; i < held_len; i++)
                        line_bytes[i-1] = line_bytes[i];
                    held_len--;
                end
            end
            CMD_READ:
            begin
                if (int'(ix) < held_len) begin
                    st.rbyte = line_bytes[ix];
                    st.rvalid = 1'b1;
                end
            end
            default: ;
        endcase
        st.cursor = CNT_W'(cur);
        st.length = CNT_W'(held_len);
        expected_status.push_back(st);
    endfunction

    function void check_status(line_status_t got);
        line_status_t want;
        if (expected_status.size() == 0) begin
            $error("result with no command outstanding: cursor %0d length %0d",
                   got.cursor, got.length);
            errors++;
            return;
        end
        want = expected_status.pop_front();
        if (got.cursor !== want.cursor) begin
            $error("cursor_pos: expected %0d, actual %0d", want.cursor, got.cursor);
            errors++;
        end
        if (got.length !== want.length) begin
            $error("fill_length: expected %0d, actual %0d", want.length, got.length);
            errors++;
        end
        if (got.rbyte !== want.rbyte) begin
            $error("read_byte: expected 0x%02h, actual 0x%02h", want.rbyte, got.rbyte);
            errors++;
        end
        if (got.rvalid !== want.rvalid) begin
            $error("read_valid: expected %0b, actual %0b", want.rvalid, got.rvalid);
            errors++;
        end
        if (got.dropped !== want.dropped) begin
            $error("insert_dropped: expected %0b, actual %0b", want.dropped, got.dropped);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int TOTAL_EDITS = 1100;

    typedef enum int {EP_FILL, EP_DRAIN, EP_MIX} edit_phase_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [CMD_W-1:0]  cmd = '0;
    logic [BYTE_W-1:0] char_in = '0;
    logic [IDX_W-1:0]  read_index = '0;
    logic              busy;
    logic              done;
    logic [CNT_W-1:0]  cursor_pos;
    logic [CNT_W-1:0]  fill_length;
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              insert_dropped;

    line_shadow shadow = new();
    bit         no_idle = 1'b0;
    int         sent = 0;

    cursor_line_edit_buffer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .char_in        (char_in),
        .read_index     (read_index),
        .done           (done),
        .cursor_pos     (cursor_pos),
        .fill_length    (fill_length),
        .read_byte      (read_byte),
        .read_valid     (read_valid),
        .insert_dropped (insert_dropped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            shadow.note_command(cmd, char_in, read_index);
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_status({cursor_pos, fill_length, read_byte, read_valid,
                                 insert_dropped});
    end

    // Leaves start high after the transfer so back-to-back commands need no extra step.
    task automatic send_edit(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] ch,
                             input logic [IDX_W-1:0] ix);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= op;
        char_in <= ch;
        read_index <= ix;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    // Drop start and let the current clock edge pass first so the last transfer is already noted.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (shadow.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        if (shadow.held_len > 0 && $urandom_range(0, 3) != 0)
            return IDX_W'($urandom_range(0, shadow.held_len - 1));
        return IDX_W'($urandom_range(0, DEPTH - 1));
    endfunction

    function automatic logic [CMD_W-1:0] pick_edit(edit_phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            EP_FILL:
            begin
                if (r < 75) return CMD_INSERT;
                if (r < 82) return CMD_BACK;
                if (r < 88) return CMD_READ;
                if (r < 92) return CMD_START;
                if (r < 96) return CMD_END;
                return CMD_FWD;
            end
            EP_DRAIN:
            begin
                if (r < 55) return CMD_DELETE;
                if (r < 70) return CMD_BACK;
                if (r < 78) return CMD_START;
                if (r < 88) return CMD_READ;
                if (r < 94) return CMD_FWD;
                return CMD_INSERT;
            end
            default:
            begin
                if (r < 2) return CMD_UNUSED;
                return CMD_FWD + CMD_W'($urandom_range(0, 6));
            end
        endcase
    endfunction

    task automatic directed_edits();
        send_edit(CMD_READ, 8'h00, '0);           // empty line reads nothing
        send_edit(CMD_READ, 8'h00, '1);
        send_edit(CMD_BACK, 8'h00, '0);           // back at start holds
        send_edit(CMD_FWD, 8'h00, '0);            // forward at end holds
        send_edit(CMD_DELETE, 8'h00, '0);         // delete at end does nothing
        send_edit(CMD_UNUSED, 8'hFF, '1);
        send_edit(CMD_INSERT, 8'h00, '0);
        send_edit(CMD_INSERT, 8'hFF, '1);
        send_edit(CMD_INSERT, 8'hAA, '0);
        send_edit(CMD_BACK, 8'h00, '0);
        send_edit(CMD_INSERT, 8'h55, '0);         // insert mid-line
        send_edit(CMD_FWD, 8'h00, '0);
        send_edit(CMD_FWD, 8'h00, '0);
        send_edit(CMD_START, 8'h00, '0);
        send_edit(CMD_INSERT, 8'h81, '0);
        send_edit(CMD_READ, 8'h00, 6'd0);
        send_edit(CMD_READ, 8'h00, 6'd4);
        send_edit(CMD_READ, 8'h00, 6'd5);         // first index past the end
        send_edit(CMD_DELETE, 8'h00, '0);         // delete at cursor mid-line
        send_edit(CMD_END, 8'h00, '0);
        send_edit(CMD_DELETE, 8'h00, '0);
        send_edit(CMD_READ, 8'h00, 6'd3);
        send_edit(CMD_START, 8'h00, '0);
        send_edit(CMD_READ, 8'h00, '1);
    endtask

    initial
    begin
        edit_phase_t ph;
        int span;
        int guard;
        bit paused;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_edits();

        // Fill to capacity once so inserts on a full line are hit early.
        repeat (DEPTH + 3)
            send_edit(CMD_INSERT, BYTE_W'($urandom_range(0, 255)), pick_index());
        send_edit(CMD_READ, 8'h00, '1);

        while (sent < TOTAL_EDITS) begin
            ph = edit_phase_t'($urandom_range(0, 2));
            span = $urandom_range(20, 110);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (span)
                send_edit(pick_edit(ph), BYTE_W'($urandom_range(0, 255)), pick_index());
            if (!paused && sent > TOTAL_EDITS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        start <= 1'b0;

        guard = 0;
        while (shadow.pending() != 0 && guard < 1000) begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (shadow.pending() != 0)
            $error("%0d results never came", shadow.pending());

        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
